// File: hw/rtl/fbm_pkg.sv
`timescale 1ns / 1ps

package fbm_pkg;

    localparam int FRAME_COUNT_DEF = 4096;
    localparam int FRAME_LIMIT     = 4096;
    localparam int WORD_BITS       = 32;
    localparam int BIT_W           = 5;
    localparam int FRAME_W         = 12;
    localparam int STATUS_W        = 3;
    localparam int IN_DATA_W       = 16;
    localparam int OUT_DATA_W      = 24;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 3'd0,
        ST_HELD      = 3'd1,
        ST_FULL      = 3'd2,
        ST_FREED     = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_mode;

endpackage

// File: hw/rtl/fbm_ram.sv
`timescale 1ns / 1ps

module fbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/frame_bitmap_allocator_core.sv
`timescale 1ns / 1ps

// Bitmap frame allocator: one used bit per 4 KiB frame, lowest free frame first.
// Request channel (s): tuser = mode (0 allocate, 1 free); tdata = current_frame,
// kernel_page, writable_page. Response channel (m): one beat per request carrying
// new_frame, present, read_write, user_mode, entry_updated and status.
// Requests that need no bitmap access (frame already held, nothing to free,
// no free frame, free above the searched range) answer in the cycle after
// acceptance and leave the block in S_IDLE for the next request. Allocations and
// in-range frees read the bitmap word from the RAM (registered read) and write
// it back: the block waits in S_MOD, accepting nothing, and loads the response
// together with the write-back. A per-word full vector in flip-flops picks the
// word to read combinationally. Reset clears the full vector and the per-word
// valid bits, so every frame reads as free without a RAM clearing pass; the
// block accepts a request in the first cycle after reset. A stalled response
// holds in the output register and s_tready stays low until that beat is
// taken; a request in the middle of its read-modify-write holds its write-back
// until the output register is free.

module frame_bitmap_allocator_core #(
    parameter int FRAME_COUNT = fbm_pkg::FRAME_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [fbm_pkg::IN_DATA_W-1:0]   i_s_tdata,   // current_frame, kernel_page,
                                                         // writable_page
    input  logic                            i_s_tuser,   // mode
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [fbm_pkg::OUT_DATA_W-1:0]  o_m_tdata    // new_frame, present, read_write,
                                                         // user_mode, entry_updated, status
);

    import fbm_pkg::*;

    localparam int SEARCH_FRAMES = (FRAME_COUNT > FRAME_LIMIT) ? FRAME_LIMIT : FRAME_COUNT;
    localparam int SW            = SEARCH_FRAMES / WORD_BITS;
    localparam int WAW           = (SW > 1) ? $clog2(SW) : 1;

    typedef enum logic {
        S_IDLE,
        S_MOD
    } t_state;

    t_state                r_state;
    logic                  r_mode;
    logic [BIT_W-1:0]      r_bit_free;
    logic                  r_kern;
    logic                  r_wr;
    logic [WAW-1:0]        r_widx;
    logic [SW-1:0]         r_full;
    logic [SW-1:0]         r_wvalid;

    logic                  r_ovalid;
    logic [FRAME_W-1:0]    r_nf;
    logic                  r_pr;
    logic                  r_rw;
    logic                  r_us;
    logic                  r_upd;
    t_status               r_status;

    logic [FRAME_W-1:0]    c_cur;
    logic                  c_kern;
    logic                  c_wr;
    logic                  c_out_free;
    logic                  c_accept;
    logic                  c_load;
    logic                  c_any_free;
    logic [WAW-1:0]        c_word_idx;
    logic [WAW-1:0]        c_cur_widx;
    logic                  c_in_range;
    logic [WORD_BITS-1:0]  c_ram_rdata;
    logic [WORD_BITS-1:0]  c_word;
    logic [BIT_W-1:0]      c_bit;
    logic [WORD_BITS-1:0]  c_set_word;
    logic [WORD_BITS-1:0]  c_clr_word;
    logic                  c_re;
    logic [WAW-1:0]        c_raddr;
    logic                  c_we;

    assign c_cur      = i_s_tdata[FRAME_W-1:0];
    assign c_kern     = i_s_tdata[FRAME_W];
    assign c_wr       = i_s_tdata[FRAME_W+1];
    assign c_out_free = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && c_out_free;
    assign c_accept   = i_s_tvalid && o_s_tready;
    assign c_load     = (r_state == S_IDLE) ? (c_accept && !c_re) : c_out_free;
    assign c_cur_widx = c_cur[WAW+BIT_W-1:BIT_W];
    assign c_in_range = {1'b0, c_cur} < (FRAME_W+1)'(SW * WORD_BITS);

    always_comb begin
        c_any_free = 1'b0;
        c_word_idx = '0;
        for (int i = SW - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                c_any_free = 1'b1;
                c_word_idx = WAW'(i);
            end
        end
    end

    assign c_word = r_wvalid[r_widx] ? c_ram_rdata : '0;

    always_comb begin
        c_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!c_word[b]) begin
                c_bit = BIT_W'(b);
            end
        end
    end

    assign c_set_word = c_word | (WORD_BITS'(1) << c_bit);
    assign c_clr_word = c_word & ~(WORD_BITS'(1) << r_bit_free);

    always_comb begin
        c_re    = 1'b0;
        c_raddr = c_cur_widx;
        if (c_accept) begin
            if (i_s_tuser == MODE_ALLOC) begin
                c_re    = (c_cur == '0) && c_any_free;
                c_raddr = c_word_idx;
            end else begin
                c_re    = (c_cur != '0) && c_in_range;
                c_raddr = c_cur_widx;
            end
        end
    end

    assign c_we = (r_state == S_MOD) && c_out_free;

    fbm_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (SW),
        .AW    (WAW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (r_widx),
        .i_wdata (r_mode ? c_clr_word : c_set_word),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (c_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_full   <= '0;
            r_wvalid <= '0;
        end else begin
            if (c_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (c_accept) begin
                        r_mode     <= i_s_tuser;
                        r_kern     <= c_kern;
                        r_wr       <= c_wr;
                        r_bit_free <= c_cur[BIT_W-1:0];
                        r_widx     <= c_raddr;
                        r_nf       <= '0;
                        r_pr       <= 1'b0;
                        r_rw       <= 1'b0;
                        r_us       <= 1'b0;
                        r_upd      <= 1'b0;
                        if (c_re) begin
                            r_state <= S_MOD;
                        end else begin
                            if (i_s_tuser == MODE_ALLOC) begin
                                if (c_cur != '0) begin
                                    r_nf     <= c_cur;
                                    r_status <= ST_HELD;
                                end else begin
                                    r_status <= ST_FULL;
                                end
                            end else begin
                                r_status <= (c_cur == '0) ? ST_EMPTY : ST_FREED;
                            end
                        end
                    end
                end
                S_MOD: begin
                    if (c_out_free) begin
                        r_state          <= S_IDLE;
                        r_wvalid[r_widx] <= 1'b1;
                        if (r_mode == MODE_FREE) begin
                            r_full[r_widx] <= 1'b0;
                            r_status       <= ST_FREED;
                        end else begin
                            r_full[r_widx] <= &c_set_word;
                            r_nf           <= FRAME_W'({r_widx, c_bit});
                            r_pr           <= 1'b1;
                            r_rw           <= r_wr;
                            r_us           <= !r_kern;
                            r_upd          <= 1'b1;
                            r_status       <= ST_ALLOCATED;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {(OUT_DATA_W-FRAME_W-4-STATUS_W)'(0), r_status, r_upd, r_us, r_rw,
                         r_pr, r_nf};

endmodule

// File: hw/rtl/fbm_chk.sv
`timescale 1ns / 1ps

module fbm_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [fbm_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input logic                            i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [fbm_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    import fbm_pkg::*;

    logic [FRAME_W-1:0]  c_nf;
    logic                c_pr;
    logic                c_rw;
    logic                c_us;
    logic                c_upd;
    logic [STATUS_W-1:0] c_st;

    assign c_nf  = o_m_tdata[FRAME_W-1:0];
    assign c_pr  = o_m_tdata[FRAME_W];
    assign c_rw  = o_m_tdata[FRAME_W+1];
    assign c_us  = o_m_tdata[FRAME_W+2];
    assign c_upd = o_m_tdata[FRAME_W+3];
    assign c_st  = o_m_tdata[FRAME_W+4+STATUS_W-1:FRAME_W+4];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("response beat dropped or changed under stall");

    a_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (c_upd == (c_st == ST_ALLOCATED)) && (c_pr == c_upd))
        else $error("entry update flags disagree with status");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !c_upd |-> !c_rw && !c_us)
        else $error("rw or user set without entry update");

    a_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (c_st == ST_FULL || c_st == ST_FREED || c_st == ST_EMPTY)
        |-> c_nf == '0)
        else $error("nonzero frame on full or free response");

    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (c_st == ST_HELD) |-> c_nf != '0)
        else $error("held response without a frame");

endmodule

bind frame_bitmap_allocator_core fbm_chk u_fbm_chk (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import fbm_pkg::*;

    localparam int FRAMES       = FRAME_COUNT_DEF;
    localparam int SEARCH_WORDS = ((FRAMES < FRAME_LIMIT) ? FRAMES : FRAME_LIMIT) / WORD_BITS;
    localparam int MAP_WORDS    = (FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [FRAME_W-1:0] new_frame;
        logic               present;
        logic               read_write;
        logic               user_mode;
        logic               entry_updated;
        t_status            status;
    } t_answer;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // current_frame, kernel_page, writable_page
    logic                  s_tuser;   // mode
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // new_frame, present, read_write, user_mode,
                                      // entry_updated, status

    logic [WORD_BITS-1:0]  used_map [0:MAP_WORDS-1];
    t_answer               answers_due [$];
    logic [FRAME_W-1:0]    frames_out [$];
    int                    mismatch_count = 0;
    int                    stall_cycles = 0;
    bit                    idle_on = 1'b1;
    int                    hold_asked = 0;
    int                    hold_given = 0;

    frame_bitmap_allocator_core #(
        .FRAME_COUNT(FRAMES)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic t_answer bitmap_answer(input t_mode mode, input logic [FRAME_W-1:0] cur,
                                              input logic kern, input logic wr);
        t_answer a;
        int      w;
        int      b;
        int      f;
        a.new_frame     = '0;
        a.present       = 1'b0;
        a.read_write    = 1'b0;
        a.user_mode     = 1'b0;
        a.entry_updated = 1'b0;
        a.status        = ST_EMPTY;
        if (mode == MODE_ALLOC) begin
            if (cur != '0) begin
                a.new_frame = cur;
                a.status    = ST_HELD;
            end else begin
                f = -1;
                for (w = 0; w < SEARCH_WORDS && f < 0; w++) begin
                    if (used_map[w] != '1) begin
                        for (b = 0; b < WORD_BITS && f < 0; b++) begin
                            if (!used_map[w][b]) begin
                                f = w * WORD_BITS + b;
                            end
                        end
                    end
                end
                if (f >= 0) begin
                    used_map[f / WORD_BITS][f % WORD_BITS] = 1'b1;
                    a.new_frame     = FRAME_W'(f);
                    a.present       = 1'b1;
                    a.read_write    = wr;
                    a.user_mode     = ~kern;
                    a.entry_updated = 1'b1;
                    a.status        = ST_ALLOCATED;
                end else begin
                    a.status = ST_FULL;
                end
            end
        end else if (cur != '0) begin
            if (int'(cur) < FRAMES) begin
                used_map[int'(cur) / WORD_BITS][int'(cur) % WORD_BITS] = 1'b0;
            end
            a.status = ST_FREED;
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    task automatic send_request(input t_mode mode, input logic [FRAME_W-1:0] cur,
                                input logic kern, input logic wr);
        t_answer ans;
        int      gap;
        int      i;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, wr, kern, cur};
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        ans = bitmap_answer(mode, cur, kern, wr);
        answers_due.push_back(ans);
        if (mode == MODE_ALLOC && ans.status == ST_ALLOCATED && ans.new_frame != '0) begin
            frames_out.push_back(ans.new_frame);
        end
        if (mode == MODE_FREE && cur != '0) begin
            for (i = 0; i < frames_out.size(); i++) begin
                if (frames_out[i] == cur) begin
                    frames_out.delete(i);
                    break;
                end
            end
        end
    endtask

    task automatic send_random_mix(input int count);
        int                 n;
        int                 r;
        logic [FRAME_W-1:0] f;
        for (n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_request(MODE_ALLOC, '0, rand_bit(), rand_bit());
            end else if (r < 70 && frames_out.size() > 0) begin
                f = frames_out[$urandom_range(0, frames_out.size() - 1)];
                send_request(MODE_FREE, f, rand_bit(), rand_bit());
            end else if (r < 80) begin
                send_request(MODE_ALLOC, FRAME_W'($urandom_range(1, 4095)),
                             rand_bit(), rand_bit());
            end else if (r < 92) begin
                send_request(MODE_FREE, FRAME_W'($urandom_range(1, 4095)),
                             rand_bit(), rand_bit());
            end else if (r < 96) begin
                send_request(MODE_FREE, '0, rand_bit(), rand_bit());
            end else begin
                send_request(t_mode'($urandom_range(0, 1)), FRAME_W'($urandom_range(0, 4095)),
                             rand_bit(), rand_bit());
            end
        end
    endtask

    task automatic test_directed();
        send_request(MODE_ALLOC, 12'd0, 1'b1, 1'b0);
        send_request(MODE_ALLOC, 12'd0, 1'b0, 1'b1);
        send_request(MODE_ALLOC, 12'd0, 1'b1, 1'b1);
        send_request(MODE_ALLOC, 12'd0, 1'b0, 1'b0);
        send_request(MODE_ALLOC, 12'd4095, 1'b1, 1'b1);
        send_request(MODE_ALLOC, 12'd1, 1'b0, 1'b0);
        send_request(MODE_FREE, 12'd0, 1'b1, 1'b1);
        send_request(MODE_FREE, 12'd1, 1'b0, 1'b1);
        send_request(MODE_ALLOC, 12'd0, 1'b0, 1'b1);
        send_request(MODE_FREE, 12'd4095, 1'b0, 1'b0);
        send_request(MODE_FREE, 12'd2, 1'b1, 1'b0);
        send_request(MODE_FREE, 12'd3, 1'b0, 1'b0);
        send_request(MODE_ALLOC, 12'd0, 1'b1, 1'b0);
        send_request(MODE_ALLOC, 12'd0, 1'b0, 1'b1);
        send_request(MODE_FREE, 12'h800, 1'b0, 1'b0);
        send_request(MODE_FREE, 12'haaa, 1'b1, 1'b1);
        send_request(MODE_FREE, 12'h555, 1'b0, 1'b1);
        send_request(MODE_ALLOC, 12'h555, 1'b1, 1'b0);
        send_request(MODE_ALLOC, 12'haaa, 1'b0, 1'b1);
        send_request(MODE_ALLOC, 12'd0, 1'b1, 1'b1);
    endtask

    task automatic test_random_mix();
        send_random_mix(1200);
    endtask

    task automatic test_backpressure();
        hold_asked++;
        send_random_mix(24);
    endtask

    task automatic test_no_idle();
        int n;
        idle_on = 1'b0;
        for (n = 0; n < 40; n++) begin
            send_request(MODE_ALLOC, '0, rand_bit(), rand_bit());
        end
        for (n = 0; n < 8 && frames_out.size() > 0; n++) begin
            send_request(MODE_FREE, frames_out[$urandom_range(0, frames_out.size() - 1)],
                         1'b0, 1'b0);
        end
        for (n = 0; n < 10; n++) begin
            send_request(MODE_ALLOC, '0, rand_bit(), rand_bit());
        end
    endtask

    initial begin
        forever begin
            if (hold_given < hold_asked) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_given++;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin : beat_check
        t_answer want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready) begin
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected beat, tdata", 0, int'(m_tdata));
            end else begin
                want = answers_due.pop_front();
                if (m_tdata[11:0] !== want.new_frame)
                    report_mismatch("new_frame", int'(want.new_frame), int'(m_tdata[11:0]));
                if (m_tdata[12] !== want.present)
                    report_mismatch("present", int'(want.present), int'(m_tdata[12]));
                if (m_tdata[13] !== want.read_write)
                    report_mismatch("read_write", int'(want.read_write), int'(m_tdata[13]));
                if (m_tdata[14] !== want.user_mode)
                    report_mismatch("user_mode", int'(want.user_mode), int'(m_tdata[14]));
                if (m_tdata[15] !== want.entry_updated)
                    report_mismatch("entry_updated", int'(want.entry_updated),
                                    int'(m_tdata[15]));
                if (m_tdata[18:16] !== want.status)
                    report_mismatch("status", int'(want.status), int'(m_tdata[18:16]));
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT: no beat for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : run
        int w;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_ALLOC;
        for (w = 0; w < MAP_WORDS; w++) begin
            used_map[w] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_mix();
        test_backpressure();
        test_no_idle();
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
